>>> sv/wake_burst_power_sequencer_macros.svh
// assertion macros used by the wake burst power sequencer checker
`ifndef WAKE_BURST_POWER_SEQUENCER_MACROS_SVH
`define WAKE_BURST_POWER_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define WBPS_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbps check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define WBPS_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbps check failed: next-cycle implication");

`endif

>>> sv/wbps_pkg.sv
// shared types and constants of the wake burst power sequencer
package wbps_pkg;

   typedef enum logic [1:0] {
      ST_MONITOR = 2'd0,
      ST_SUPPLY  = 2'd1,
      ST_POWER   = 2'd2,
      ST_PASS    = 2'd3
   } seq_state_type;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_REPORT = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [2:0] CSR_PSU_SETTLE    = 3'd0;
   localparam logic [2:0] CSR_BOOT_TIMEOUT  = 3'd1;
   localparam logic [2:0] CSR_OFF_CONFIRM   = 3'd2;
   localparam logic [2:0] CSR_COOLDOWN      = 3'd3;
   localparam logic [2:0] CSR_MIN_SILENCE   = 3'd4;
   localparam logic [2:0] CSR_BURST_WINDOW  = 3'd5;
   localparam logic [2:0] CSR_BURST_THRESH  = 3'd6;
   localparam logic [2:0] CSR_REARM_SILENCE = 3'd7;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 8;

   localparam logic [31:0] RST_PSU_SETTLE    = 32'd1000;
   localparam logic [31:0] RST_BOOT_TIMEOUT  = 32'd90000;
   localparam logic [31:0] RST_OFF_CONFIRM   = 32'd3000;
   localparam logic [31:0] RST_COOLDOWN      = 32'd10000;
   localparam logic [31:0] RST_MIN_SILENCE   = 32'd800;
   localparam logic [31:0] RST_BURST_WINDOW  = 32'd200;
   localparam logic [7:0]  RST_BURST_THRESH  = 8'd3;
   localparam logic [31:0] RST_REARM_SILENCE = 32'd1500;

   localparam logic [31:0] BLINK_HALF_MS = 32'd500;
   localparam logic [31:0] PREFIX_ONE    = 32'h0100013C;
   localparam logic [31:0] PREFIX_TWO    = 32'h0100040B;
   localparam logic [31:0] PREFIX_THREE  = 32'h01000301;
   localparam logic [6:0]  MIN_REPORT_LEN = 7'd4;

   typedef struct packed {
      logic [31:0] min_silence_ms;
      logic [31:0] burst_window_ms;
      logic [7:0]  burst_threshold;
      logic [31:0] rearm_silence_ms;
   } det_cfg_type;

   typedef struct packed {
      logic clear;
      logic count;
      logic consume;
   } det_ctrl_type;

   typedef struct packed {
      logic armed_in;
      logic pending;
   } det_stat_type;

endpackage

>>> sv/wake_burst_power_sequencer.sv
// wake burst power sequencer top level: event stream in, status stream out
// an accepted transaction is held in the input register, stepped into the result
// register once rsp is free or being taken, and offered on rsp from there
// throughput: one transaction per cycle while rsp is not stalled, the step being a
// single pass of logic between the input register and the result register
// reset: synchronous, active high; clears sequence and detector state and loads
// the register defaults, no clearing pass
module wake_burst_power_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_ms, report_prefix, report_len, host_vbus, device_vbus, hid_ready,
   // target_present, zero fill
   input  logic [wbps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // seq_state, psu_on, path_to_host, button_press, led_on, wake_armed, zero fill
   output logic [wbps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [wbps_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wbps_pkg::*;

   // configuration registers
   logic [31:0] psu_settle_ff, boot_timeout_ff, off_confirm_ff, cooldown_ff;
   logic [31:0] min_silence_ff, burst_window_ff, rearm_silence_ff;
   logic [7:0]  burst_thresh_ff;

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_mode_ff;
   logic [74:0] in_data_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // sequence state
   seq_state_type state_ff, state_in;
   logic [31:0] psu_start_ff, psu_start_in;
   logic [31:0] boot_start_ff, boot_start_in;
   logic [31:0] host_lost_ff, host_lost_in;
   logic [31:0] cool_until_ff, cool_until_in;
   logic [31:0] toggle_ff, toggle_in;
   logic        blink_ff, blink_in;
   logic        led_ff, led_in;
   logic        supply_ff, supply_in;
   logic        path_ff, path_in;
   logic        press;

   logic        advance, tick, match;
   logic [31:0] now_ms, prefix;
   logic [6:0]  report_len;
   logic        host_vbus, device_vbus, hid_ready, target_present, present;
   logic        cool_active, wake, consume;
   logic [31:0] since_toggle, since_psu, since_boot, since_lost;

   det_cfg_type  det_cfg;
   det_ctrl_type det_ctrl;
   det_stat_type det_stat;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         psu_settle_ff    <= RST_PSU_SETTLE;
         boot_timeout_ff  <= RST_BOOT_TIMEOUT;
         off_confirm_ff   <= RST_OFF_CONFIRM;
         cooldown_ff      <= RST_COOLDOWN;
         min_silence_ff   <= RST_MIN_SILENCE;
         burst_window_ff  <= RST_BURST_WINDOW;
         burst_thresh_ff  <= RST_BURST_THRESH;
         rearm_silence_ff <= RST_REARM_SILENCE;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PSU_SETTLE:    psu_settle_ff    <= csr_wdata;
            CSR_BOOT_TIMEOUT:  boot_timeout_ff  <= csr_wdata;
            CSR_OFF_CONFIRM:   off_confirm_ff   <= csr_wdata;
            CSR_COOLDOWN:      cooldown_ff      <= csr_wdata;
            CSR_MIN_SILENCE:   min_silence_ff   <= csr_wdata;
            CSR_BURST_WINDOW:  burst_window_ff  <= csr_wdata;
            CSR_BURST_THRESH:  burst_thresh_ff  <= csr_wdata[7:0];
            CSR_REARM_SILENCE: rearm_silence_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser;
         in_data_ff <= req_tdata[74:0];
      end
   end

   assign now_ms         = in_data_ff[31:0];
   assign prefix         = in_data_ff[63:32];
   assign report_len     = in_data_ff[70:64];
   assign host_vbus      = in_data_ff[71];
   assign device_vbus    = in_data_ff[72];
   assign hid_ready      = in_data_ff[73];
   assign target_present = in_data_ff[74];

   assign tick  = advance && (in_mode_ff == MODE_TICK);
   assign match = (report_len >= MIN_REPORT_LEN) &&
                  (prefix == PREFIX_ONE || prefix == PREFIX_TWO || prefix == PREFIX_THREE);

   assign present      = hid_ready ? target_present : device_vbus;
   // plain compare, no wrap: a cooldown end of zero means none
   assign cool_active  = (cool_until_ff != 32'd0) && (now_ms < cool_until_ff);
   assign wake         = !cool_active && (hid_ready ? det_stat.pending : device_vbus);
   assign consume      = tick && (state_ff == ST_MONITOR) && !cool_active && hid_ready;
   assign since_toggle = now_ms - toggle_ff;
   assign since_psu    = now_ms - psu_start_ff;
   assign since_boot   = now_ms - boot_start_ff;
   assign since_lost   = now_ms - host_lost_ff;

   assign det_cfg.min_silence_ms   = min_silence_ff;
   assign det_cfg.burst_window_ms  = burst_window_ff;
   assign det_cfg.burst_threshold  = burst_thresh_ff;
   assign det_cfg.rearm_silence_ms = rearm_silence_ff;
   assign det_ctrl.clear   = advance && (in_mode_ff == MODE_CLEAR);
   assign det_ctrl.count   = advance && (in_mode_ff == MODE_REPORT) && match;
   assign det_ctrl.consume = consume;

   wbps_detector u_detector (
      .clock  (clock),
      .reset  (reset),
      .cfg    (det_cfg),
      .ctrl   (det_ctrl),
      .now_ms (now_ms),
      .stat   (det_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      if (tick) begin
         case (state_ff)
            ST_MONITOR: begin
               if (wake) begin
                  state_in = host_vbus ? ST_PASS : ST_SUPPLY;
               end
            end
            ST_SUPPLY: begin
               if (!present) begin
                  state_in = ST_MONITOR;
               end else if (since_psu >= psu_settle_ff) begin
                  state_in = ST_POWER;
               end
            end
            ST_POWER: begin
               if (!present) begin
                  state_in = ST_MONITOR;
               end else if (host_vbus) begin
                  state_in = ST_PASS;
               end else if (since_boot > boot_timeout_ff) begin
                  state_in = ST_MONITOR;
               end
            end
            ST_PASS: begin
               if (!host_vbus && host_lost_ff != 32'd0 && since_lost > off_confirm_ff) begin
                  state_in = ST_MONITOR;
               end
            end
            default: state_in = state_ff;
         endcase
      end
   end

   // outputs and timers
   always_comb begin
      psu_start_in  = psu_start_ff;
      boot_start_in = boot_start_ff;
      host_lost_in  = host_lost_ff;
      cool_until_in = cool_until_ff;
      toggle_in     = toggle_ff;
      blink_in      = blink_ff;
      led_in        = led_ff;
      supply_in     = supply_ff;
      path_in       = path_ff;
      press         = 1'b0;
      if (tick) begin
         if (host_vbus) begin
            led_in = 1'b1;
         end else if (since_toggle >= BLINK_HALF_MS) begin
            toggle_in = now_ms;
            blink_in  = !blink_ff;
            led_in    = !blink_ff;
         end
         case (state_ff)
            ST_MONITOR: begin
               if (wake) begin
                  if (host_vbus) begin
                     path_in = 1'b1;
                  end else begin
                     supply_in    = 1'b1;
                     psu_start_in = now_ms;
                  end
               end
            end
            ST_SUPPLY: begin
               if (!present) begin
                  supply_in = 1'b0;
               end else if (since_psu >= psu_settle_ff) begin
                  press         = 1'b1;
                  boot_start_in = now_ms;
               end
            end
            ST_POWER: begin
               if (!present) begin
                  supply_in = 1'b0;
               end else if (host_vbus) begin
                  path_in      = 1'b1;
                  host_lost_in = 32'd0;
               end else if (since_boot > boot_timeout_ff) begin
                  supply_in = 1'b0;
               end
            end
            ST_PASS: begin
               if (host_vbus) begin
                  host_lost_in = 32'd0;
               end else if (host_lost_ff == 32'd0) begin
                  host_lost_in = now_ms;
               end else if (since_lost > off_confirm_ff) begin
                  supply_in     = 1'b0;
                  path_in       = 1'b0;
                  host_lost_in  = 32'd0;
                  cool_until_in = (cooldown_ff == 32'd0) ? 32'd0 : now_ms + cooldown_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_MONITOR;
         psu_start_ff  <= 32'd0;
         boot_start_ff <= 32'd0;
         host_lost_ff  <= 32'd0;
         cool_until_ff <= 32'd0;
         toggle_ff     <= 32'd0;
         blink_ff      <= 1'b0;
         led_ff        <= 1'b0;
         supply_ff     <= 1'b0;
         path_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         psu_start_ff  <= psu_start_in;
         boot_start_ff <= boot_start_in;
         host_lost_ff  <= host_lost_in;
         cool_until_ff <= cool_until_in;
         toggle_ff     <= toggle_in;
         blink_ff      <= blink_in;
         led_ff        <= led_in;
         supply_ff     <= supply_in;
         path_ff       <= path_in;
      end
   end

   assign rsp_data_in = {1'b0, det_stat.armed_in, led_in, press, path_in, supply_in, state_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> sv/wbps_detector.sv
// burst detector: counts matching reports into bursts and holds the wake flag
module wbps_detector (
   input  logic                 clock,
   input  logic                 reset,
   input  wbps_pkg::det_cfg_type  cfg,
   input  wbps_pkg::det_ctrl_type ctrl,
   input  logic [31:0]          now_ms,
   output wbps_pkg::det_stat_type stat
);
   import wbps_pkg::*;

   logic        armed_ff, armed_in;
   logic        pending_ff, pending_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] start_ff, start_in;
   logic [7:0]  count_ff, count_in;

   logic [31:0] since_last, since_start;
   logic        rearm_ok, restart, fresh, keep_start, in_window;
   logic [7:0]  count_base;

   assign since_last  = now_ms - last_ff;
   assign since_start = now_ms - start_ff;
   assign rearm_ok    = (last_ff != 32'd0) && (since_last >= cfg.rearm_silence_ms);
   assign restart     = (last_ff == 32'd0) || (since_last > cfg.min_silence_ms);
   // a re-arm or a long silence starts the burst at this report
   assign fresh       = !armed_ff || restart;
   assign keep_start  = !fresh && (start_ff != 32'd0);
   assign in_window   = !keep_start || (since_start <= cfg.burst_window_ms);
   assign count_base  = fresh ? 8'd0 : count_ff;

   always_comb begin
      armed_in   = armed_ff;
      pending_in = pending_ff;
      last_in    = last_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      if (ctrl.clear) begin
         armed_in   = 1'b1;
         pending_in = 1'b0;
         last_in    = 32'd0;
         start_in   = 32'd0;
         count_in   = 8'd0;
      end else if (ctrl.count) begin
         last_in = now_ms;
         if (armed_ff || rearm_ok) begin
            if (in_window) begin
               count_in = (count_base == 8'hFF) ? count_base : count_base + 8'd1;
               start_in = keep_start ? start_ff : now_ms;
            end else begin
               count_in = 8'd1;
               start_in = now_ms;
            end
            armed_in = 1'b1;
            if (count_in >= cfg.burst_threshold) begin
               pending_in = 1'b1;
               armed_in   = 1'b0;
            end
         end
      end else if (ctrl.consume) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b1;
         pending_ff <= 1'b0;
         last_ff    <= 32'd0;
         start_ff   <= 32'd0;
         count_ff   <= 8'd0;
      end else begin
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         last_ff    <= last_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
      end
   end

   assign stat.armed_in = armed_in;
   assign stat.pending  = pending_ff;

endmodule

>>> sv/wbps_checker.sv
// port-level checks for the wake burst power sequencer and their bind
`include "wake_burst_power_sequencer_macros.svh"

module wbps_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wbps_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import wbps_pkg::*;

   // a stalled result transaction stays offered and unchanged
   `WBPS_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the button pulse only comes with the move into powering on
   `WBPS_IMPLY(a_press_in_power, clock, reset, rsp_tvalid && rsp_tdata[4], rsp_tdata[1:0] == ST_POWER)

   // usb goes to the host only in passthrough
   `WBPS_IMPLY(a_path_in_pass, clock, reset, rsp_tvalid && rsp_tdata[3], rsp_tdata[1:0] == ST_PASS)

   // supply is on while settling and powering on
   `WBPS_IMPLY(a_supply_on, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == ST_SUPPLY || rsp_tdata[1:0] == ST_POWER), rsp_tdata[2])

endmodule

bind wake_burst_power_sequencer wbps_checker u_wbps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
